// ===== hw/rtl/base64_stream_decoder_macros.svh =====
// Assertion macros shared by the base64 stream decoder checkers.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define B64D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define B64D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, codes and the character classifier of the base64 stream decoder.
`default_nettype none

package b64d_pkg;

    // Default width of the decoded byte counter.
    localparam int LENGTH_BITS_DEF = 24;

    // Depth of the result queue; a power of two, at least four.
    localparam int RES_DEPTH = 8;

    // Most results that one input word can cause.
    localparam int MAX_RESULTS = 3;

    // Symbol codes above the six-bit alphabet.
    localparam logic [6:0] SYM_SKIP = 7'd64;
    localparam logic [6:0] SYM_PAD  = 7'd65;
    localparam logic [6:0] SYM_BAD  = 7'd66;

    // Capacity after reset.
    localparam logic [23:0] CAP_RESET = 24'hFF_FFFF;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_RUN = 2'd0,
        MODE_PAD = 2'd1,
        MODE_BAD = 2'd2,
        MODE_OVF = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_status;
        logic [1:0]  status;
        logic [23:0] out_length;
        logic        last;
    } result_t;

    // Up to three result words written into the queue in one cycle.
    typedef struct packed {
        logic [1:0]          count;
        result_t [2:0]       entries;
    } push_t;

    // Map a character code to its six-bit symbol or to a special code.
    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end else if (c == 8'h3D) begin
            s = SYM_PAD;
        end else if (c == 8'h0A) begin
            s = SYM_SKIP;
        end else begin
            s = SYM_BAD;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder.
// One character or end marker is taken per cycle whenever the eight-word result
// queue has room for three more words. Each four symbols give three byte words,
// and each end marker gives up to two leftover bytes and one status word. Words
// leave the queue one per cycle while out_stall is low; no input pattern yields
// more than one word per input word on average, and bursts of three are at least
// four input words apart, so characters follow back to back and the input stalls
// only while the output side holds words back. With an empty queue, the first
// result appears at the output in the cycle after the input word that caused it.
`default_nettype none

module base64_stream_decoder #(
    parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           cmd,
    input  wire logic [7:0]     ch,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                is_status,
    output logic [1:0]          status,
    output logic [23:0]         out_length,
    output logic                last,
    input  wire logic           cfg_we,
    input  wire logic [23:0]    cfg_data
);

    logic               accept;
    logic               pop;
    logic               full3;
    b64d_pkg::push_t    push;
    b64d_pkg::result_t  head;

    assign in_stall = full3;
    assign accept   = in_valid && !full3;
    assign pop      = out_valid && !out_stall;

    // Decoder state and result generation.
    b64d_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .ch       (ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push)
    );

    // Result queue towards the output channel.
    b64d_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .full3      (full3),
        .head_valid (out_valid),
        .head       (head)
    );

    assign out_byte   = head.out_byte;
    assign is_status  = head.is_status;
    assign status     = head.status;
    assign out_length = head.out_length;
    assign last       = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_core.sv =====
// Decode state, capacity register and result generation for one input word.
`default_nettype none

module b64d_core #(
    parameter int LENGTH_BITS = b64d_pkg::LENGTH_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic           cmd,
    input  wire logic [7:0]     ch,
    input  wire logic           cfg_we,
    input  wire logic [23:0]    cfg_data,
    output b64d_pkg::push_t     push
);

    localparam int LW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

    logic [23:0]            cap_reg;
    logic [23:0]            buf_reg, buf_next;
    logic [1:0]             sc_reg, sc_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    b64d_pkg::mode_t        mode_reg, mode_next;

    logic [6:0]             sym;
    logic [23:0]            shifted;
    logic [1:0]             need;
    logic [LW-1:0]          cap_ext, cmax_ext, lim, cnt_ext, len_ext;
    logic                   room;

    // Build a byte result word.
    function automatic b64d_pkg::result_t byte_word(input logic [7:0] b, input logic lst);
        b64d_pkg::result_t r;
        r            = '0;
        r.out_byte   = b;
        r.last       = lst;
        return r;
    endfunction

    assign sym     = b64d_pkg::classify(ch);
    assign shifted = {buf_reg[17:0], sym[5:0]};

    // Bytes that this word would add to the count.
    always_comb
    begin
        if (cmd == b64d_pkg::CMD_CHAR) begin
            need = 2'd3;
        end else if (sc_reg == 2'd3) begin
            need = 2'd2;
        end else if (sc_reg == 2'd2) begin
            need = 2'd1;
        end else begin
            need = 2'd0;
        end
    end

    // Capacity check against the smaller of the register and the counter range.
    assign cap_ext  = LW'(cap_reg);
    assign cmax_ext = LW'({LENGTH_BITS{1'b1}});
    assign lim      = (cap_ext < cmax_ext) ? cap_ext : cmax_ext;
    assign cnt_ext  = LW'(cnt_reg);
    assign room     = ({1'b0, lim} >= ({1'b0, cnt_ext} + (LW+1)'(need)));

    // Next state and the result words of this input word.
    always_comb
    begin
        b64d_pkg::mode_t end_mode;
        logic [1:0]      n;
        end_mode  = mode_reg;
        n         = 2'd0;
        push      = '0;
        buf_next  = buf_reg;
        sc_next   = sc_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        len_ext   = '0;
        if (cmd == b64d_pkg::CMD_CHAR) begin
            if (mode_reg == b64d_pkg::MODE_RUN) begin
                priority if (sym == b64d_pkg::SYM_SKIP) begin
                    mode_next = mode_reg;
                end else if (sym == b64d_pkg::SYM_BAD) begin
                    mode_next = b64d_pkg::MODE_BAD;
                end else if (sym == b64d_pkg::SYM_PAD) begin
                    mode_next = b64d_pkg::MODE_PAD;
                end else begin
                    buf_next = shifted;
                    if (sc_reg != 2'd3) begin
                        sc_next = sc_reg + 2'd1;
                    end else if (!room) begin
                        mode_next = b64d_pkg::MODE_OVF;
                    end else begin
                        push.entries[0] = byte_word(shifted[23:16], 1'b0);
                        push.entries[1] = byte_word(shifted[15:8], 1'b0);
                        push.entries[2] = byte_word(shifted[7:0], 1'b1);
                        push.count      = 2'd3;
                        cnt_next        = cnt_reg + LENGTH_BITS'(need);
                        buf_next        = '0;
                        sc_next         = 2'd0;
                    end
                end
            end
        end else begin
            // End of string: flush the leftover, then report and clear.
            if ((mode_reg == b64d_pkg::MODE_RUN) || (mode_reg == b64d_pkg::MODE_PAD)) begin
                if (sc_reg == 2'd3) begin
                    if (room) begin
                        push.entries[0] = byte_word(buf_reg[17:10], 1'b0);
                        push.entries[1] = byte_word(buf_reg[9:2], 1'b0);
                        n               = 2'd2;
                        cnt_next        = cnt_reg + LENGTH_BITS'(need);
                    end else begin
                        end_mode = b64d_pkg::MODE_OVF;
                    end
                end else if (sc_reg == 2'd2) begin
                    if (room) begin
                        push.entries[0] = byte_word(buf_reg[11:4], 1'b0);
                        n               = 2'd1;
                        cnt_next        = cnt_reg + LENGTH_BITS'(need);
                    end else begin
                        end_mode = b64d_pkg::MODE_OVF;
                    end
                end
            end
            len_ext = LW'(cnt_next);
            push.entries[n].is_status  = 1'b1;
            push.entries[n].out_length = len_ext[23:0];
            push.entries[n].last       = 1'b1;
            unique case (end_mode)
                b64d_pkg::MODE_BAD: push.entries[n].status = b64d_pkg::ST_BAD_CHAR;
                b64d_pkg::MODE_OVF: push.entries[n].status = b64d_pkg::ST_OVERFLOW;
                default:            push.entries[n].status = b64d_pkg::ST_OK;
            endcase
            push.count = n + 2'd1;
            buf_next   = '0;
            sc_next    = 2'd0;
            cnt_next   = '0;
            mode_next  = b64d_pkg::MODE_RUN;
        end
        if (!accept) begin
            push.count = 2'd0;
        end
    end

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= b64d_pkg::CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_data;
        end
    end

    // Decode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg  <= '0;
            sc_reg   <= '0;
            cnt_reg  <= '0;
            mode_reg <= b64d_pkg::MODE_RUN;
        end else if (accept) begin
            buf_reg  <= buf_next;
            sc_reg   <= sc_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_res_fifo.sv =====
// Result queue: takes up to three words a cycle and hands out one a cycle while popped.
`default_nettype none

module b64d_res_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64d_pkg::push_t    push,
    input  wire logic               pop,
    output logic                    full3,
    output logic                    head_valid,
    output b64d_pkg::result_t       head
);

    localparam int DEPTH  = b64d_pkg::RES_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    b64d_pkg::result_t  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    // Too little room for the worst case of one more input word.
    assign full3      = (count_reg > CNT_W'(DEPTH - b64d_pkg::MAX_RESULTS));

    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    // Storage: up to three consecutive slots written per cycle.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < b64d_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push.count) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push.entries[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_checker.sv =====
// Port-level checker of the base64 stream decoder and its bind statement.
`default_nettype none
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        is_status,
    input wire logic [1:0]  status,
    input wire logic [23:0] out_length,
    input wire logic        last
);

    // A stalled result word stays offered.
    `B64D_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")

    // A status word always closes the results of its input word.
    `B64D_ASSERT_IMP(a_status_last, clk, rst_n, out_valid && is_status, last && (out_byte == 8'd0), "status word not marked last or has a byte")

    // Byte words carry no status and no length.
    `B64D_ASSERT_IMP(a_byte_clean, clk, rst_n, out_valid && !is_status, (status == 2'd0) && (out_length == 24'd0), "byte word carries status fields")

    // The status code stays within its three meanings.
    `B64D_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status != 2'd3, "undefined status code")

    // An empty result queue never holds the input back.
    `B64D_ASSERT_IMP(a_empty_no_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with no result pending")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_status  (is_status),
    .status     (status),
    .out_length (out_length),
    .last       (last)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the base64 stream decoder: directed strings, then random strings.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;

    // Stimulus and response signals; the stimulus is known from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        cmd       = b64d_pkg::CMD_CHAR;
    logic [7:0]  ch        = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [23:0] out_length;
    logic        last;
    logic        cfg_we    = 1'b0;
    logic [23:0] cfg_data  = 24'h0;

    // Decoder state as the testbench expects it to be.
    logic [23:0]     capacity_now = b64d_pkg::CAP_RESET;
    logic [23:0]     sextets      = 24'h0;
    logic [1:0]      symbols_held = 2'd0;
    logic [23:0]     bytes_out    = 24'h0;
    b64d_pkg::mode_t mode_now     = b64d_pkg::MODE_RUN;

    b64d_pkg::result_t decoded_due[$];
    bit      idle_on    = 1'b1;
    int      errors     = 0;
    int      cycles     = 0;
    int      words_sent = 0;

    always #10 clk = ~clk;

    base64_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_status  (is_status),
        .status     (status),
        .out_length (out_length),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
                 what, cycles, got, want);
        errors++;
    endtask

    // Six-bit symbol of a character, or one of the special codes.
    function automatic logic [6:0] symbol_of(input logic [7:0] c);
        logic [6:0] s;
        s = b64d_pkg::SYM_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            s = 7'd62;
        end
        else if (c == 8'h2F) begin
            s = 7'd63;
        end
        else if (c == 8'h3D) begin
            s = b64d_pkg::SYM_PAD;
        end
        else if (c == 8'h0A) begin
            s = b64d_pkg::SYM_SKIP;
        end
        return s;
    endfunction

    // Alphabet character that carries a six-bit value.
    function automatic logic [7:0] char_of(input int unsigned v);
        logic [7:0] c;
        if (v < 26) begin
            c = 8'(8'h41 + v);
        end
        else if (v < 52) begin
            c = 8'(8'h61 + v - 26);
        end
        else if (v < 62) begin
            c = 8'(8'h30 + v - 52);
        end
        else if (v == 62) begin
            c = 8'h2B;
        end
        else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // True when the byte count may grow by need without passing the capacity.
    function automatic bit room_for_bytes(input int unsigned need);
        return (bytes_out <= capacity_now) && (32'(capacity_now - bytes_out) >= need);
    endfunction

    function automatic b64d_pkg::result_t make_word(input logic [7:0] b,
                                                    input logic st_flag,
                                                    input b64d_pkg::status_t st,
                                                    input logic [23:0] len,
                                                    input logic lst);
        b64d_pkg::result_t r;
        r.out_byte   = b;
        r.is_status  = st_flag;
        r.status     = st;
        r.out_length = len;
        r.last       = lst;
        return r;
    endfunction

    // Advance the expected decoder state by one input word and queue its results.
    task automatic decode_step(input b64d_pkg::cmd_t c, input logic [7:0] x);
        logic [6:0]         s;
        b64d_pkg::status_t  st;
        if (c == b64d_pkg::CMD_CHAR) begin
            if (mode_now == b64d_pkg::MODE_RUN) begin
                s = symbol_of(x);
                if (s == b64d_pkg::SYM_BAD) begin
                    mode_now = b64d_pkg::MODE_BAD;
                end
                else if (s == b64d_pkg::SYM_PAD) begin
                    mode_now = b64d_pkg::MODE_PAD;
                end
                else if (s != b64d_pkg::SYM_SKIP) begin
                    sextets = {sextets[17:0], s[5:0]};
                    if (symbols_held != 2'd3) begin
                        symbols_held = symbols_held + 2'd1;
                    end
                    else if (!room_for_bytes(3)) begin
                        mode_now = b64d_pkg::MODE_OVF;
                    end
                    else begin
                        decoded_due.push_back(make_word(sextets[23:16], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b0));
                        decoded_due.push_back(make_word(sextets[15:8], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b0));
                        decoded_due.push_back(make_word(sextets[7:0], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b1));
                        bytes_out    = bytes_out + 24'd3;
                        sextets      = 24'h0;
                        symbols_held = 2'd0;
                    end
                end
            end
        end
        else begin
            // Leftover symbols release their bytes unless decoding has failed.
            if (mode_now == b64d_pkg::MODE_RUN || mode_now == b64d_pkg::MODE_PAD) begin
                if (symbols_held == 2'd3) begin
                    if (room_for_bytes(2)) begin
                        decoded_due.push_back(make_word(sextets[17:10], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b0));
                        decoded_due.push_back(make_word(sextets[9:2], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b0));
                        bytes_out = bytes_out + 24'd2;
                    end
                    else begin
                        mode_now = b64d_pkg::MODE_OVF;
                    end
                end
                else if (symbols_held == 2'd2) begin
                    if (room_for_bytes(1)) begin
                        decoded_due.push_back(make_word(sextets[11:4], 1'b0,
                                                        b64d_pkg::ST_OK, 24'h0, 1'b0));
                        bytes_out = bytes_out + 24'd1;
                    end
                    else begin
                        mode_now = b64d_pkg::MODE_OVF;
                    end
                end
            end
            st = b64d_pkg::ST_OK;
            if (mode_now == b64d_pkg::MODE_BAD) begin
                st = b64d_pkg::ST_BAD_CHAR;
            end
            else if (mode_now == b64d_pkg::MODE_OVF) begin
                st = b64d_pkg::ST_OVERFLOW;
            end
            decoded_due.push_back(make_word(8'h00, 1'b1, st, bytes_out, 1'b1));
            sextets      = 24'h0;
            symbols_held = 2'd0;
            bytes_out    = 24'h0;
            mode_now     = b64d_pkg::MODE_RUN;
        end
    endtask

    // Offer one input word, after an optional gap, and wait until it is taken.
    task automatic send_word(input b64d_pkg::cmd_t c, input logic [7:0] x);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        decode_step(c, x);
        in_valid <= 1'b1;
        cmd      <= c;
        ch       <= x;
        words_sent++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_end();
        send_word(b64d_pkg::CMD_END, 8'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(b64d_pkg::CMD_CHAR, s[i]);
        end
    endtask

    // Hold the input idle until every result has come and the pipeline is empty.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [23:0] v);
        quiesce();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        capacity_now = v;
    endtask

    // One random string: mostly well formed, some with a bad character, some noise.
    task automatic send_random_string(input int max_syms);
        int         kind;
        int         nsym;
        int         bad_at;
        logic [7:0] x;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) send_word(b64d_pkg::CMD_CHAR, 8'($urandom));
        end
        else begin
            nsym   = $urandom_range(0, max_syms);
            bad_at = (kind == 1) ? $urandom_range(0, nsym) : -1;
            for (int i = 0; i < nsym; i++) begin
                if (i == bad_at) begin
                    x = 8'($urandom);
                    while (symbol_of(x) != b64d_pkg::SYM_BAD) x = 8'($urandom);
                    send_word(b64d_pkg::CMD_CHAR, x);
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_word(b64d_pkg::CMD_CHAR, 8'h0A);
                end
                send_word(b64d_pkg::CMD_CHAR, char_of($urandom_range(0, 63)));
            end
            // Padding, sometimes followed by a character that must be ignored.
            if (nsym % 4 >= 2 && $urandom_range(0, 1) == 1) begin
                send_word(b64d_pkg::CMD_CHAR, 8'h3D);
                if ($urandom_range(0, 1) == 1) begin
                    send_word(b64d_pkg::CMD_CHAR, 8'h3D);
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_word(b64d_pkg::CMD_CHAR, 8'($urandom));
                end
            end
        end
        send_end();
    endtask

    // Directed strings under the capacity left by reset.
    task automatic test_directed_strings();
        send_end();
        send_text("+/");
        send_word(b64d_pkg::CMD_CHAR, 8'h0A);
        send_text("9z");
        send_end();
        send_text("Zm8=Q");
        send_end();
        send_text("QQ");
        send_end();
        send_text("A");
        send_end();
        send_text("AAAA");
        send_word(b64d_pkg::CMD_CHAR, 8'h00);
        send_end();
        send_word(b64d_pkg::CMD_CHAR, 8'hFF);
        send_end();
    endtask

    task automatic test_random_at_capacity(input logic [23:0] capv, input int n_words,
                                           input int max_syms);
        int start;
        write_capacity(capv);
        start = words_sent;
        while (words_sent - start < n_words) send_random_string(max_syms);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_back_to_back(input int n_words);
        int start;
        write_capacity(24'hFF_FFFF);
        idle_on = 1'b0;
        start   = words_sent;
        while (words_sent - start < n_words) send_random_string(16);
    endtask

    // Random stall bursts on the result side.
    always @(posedge clk) begin : drive_out_stall
        int stall_left;
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (idle_on && stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
    end

    // Compare each accepted result word with the oldest one due.
    always @(posedge clk) begin : check_words
        b64d_pkg::result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_due.size() == 0) begin
                report_mismatch("word with none due", 32'({is_status, out_byte}), 32'h0);
            end
            else begin
                want = decoded_due.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(out_byte), 32'(want.out_byte));
                if (is_status !== want.is_status)
                    report_mismatch("is_status", 32'(is_status), 32'(want.is_status));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (out_length !== want.out_length)
                    report_mismatch("out_length", 32'(out_length), 32'(want.out_length));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : run_tests
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_strings();
        test_random_at_capacity(24'hFF_FFFF, 50, 16);
        test_random_at_capacity(24'h00_0000, 30, 8);
        test_random_at_capacity(24'($urandom_range(1, 12)), 50, 16);
        test_random_at_capacity(24'($urandom_range(13, 24'hFF_FFFE)), 50, 16);
        test_back_to_back(40);

        // Let the last results drain and settle.
        in_valid <= 1'b0;
        waited = 0;
        while (decoded_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (decoded_due.size() != 0) begin
            report_mismatch("words never delivered", 32'(decoded_due.size()), 32'h0);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
